[sv/gdfw_pkg.sv]
// ----------------------------------------------------------------------------
// gdfw_pkg
// Shared constants, codes and controller/datapath types for the graph
// diameter block.
// ----------------------------------------------------------------------------
package gdfw_pkg;

    localparam int MAX_NODES_DEF = 64;

    // fixed field widths
    localparam int NODE_W    = 6;
    localparam int CFG_W     = 7;
    localparam int DIAM_W    = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

    // item kinds carried on s_tuser
    localparam logic OP_EDGE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_ROW,
        ST_INIT_STREAM,
        ST_RELAX_ROW,
        ST_RELAX_STREAM,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef enum logic {
        PH_INIT,
        PH_RELAX
    } phase_t;

    typedef struct packed {
        logic   load_edge;
        logic   clr_cnt;
        logic   clr_best;
        logic   row_start;
        logic   stream;
        logic   load_result;
        logic   clr_adj;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic col_last;
        logic row_last;
        logic k_last;
    } sts_t;

endpackage

[sv/graph_diameter_floyd_warshall.sv]
// ----------------------------------------------------------------------------
// graph_diameter_floyd_warshall
// Undirected unit-cost graph diameter by all-pairs shortest paths.
// ----------------------------------------------------------------------------
// Edge items (s_tuser = 0) are taken one per cycle while the block is idle
// and go straight into the adjacency store; they give no result. A finish
// item (s_tuser = 1) holds s_tready low while the distance memory is built
// and relaxed through a two-read, one-write memory, one entry per cycle
// within a row; a row-start step opens each row and, in relaxation, fetches
// d[i][k]. With n nodes in use there are n init rows, n relaxation passes
// of n rows each, a drain step and a result step. The result then waits in
// the output register while further edge items are accepted; a new finish
// is accepted and swept as well, and the load of its result, with s_tready
// held low, waits until the older result has been taken. The adjacency store
// is emptied when the result is loaded, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module graph_diameter_floyd_warshall #(
    parameter int MAX_NODES = gdfw_pkg::MAX_NODES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // node_count
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gdfw_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gdfw_pkg::S_TDATA_W-1:0]    s_tdata,  // node_a[5:0], node_b[11:6]
    input  logic                              s_tuser,  // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gdfw_pkg::M_TDATA_W-1:0]    m_tdata   // diameter[7:0], connected[8]
);
    import gdfw_pkg::*;

    localparam int M_PAD_W = M_TDATA_W - DIAM_W - 1;

    cmd_t              cmd;
    sts_t              sts;
    logic [DIAM_W-1:0] diameter;
    logic              connected;

    assign cfg_ready = 1'b1;

    gdfw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gdfw_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .node_a    (s_tdata[NODE_W-1:0]),
        .node_b    (s_tdata[2*NODE_W-1:NODE_W]),
        .cmd       (cmd),
        .sts       (sts),
        .diameter  (diameter),
        .connected (connected)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, connected, diameter};

endmodule

[sv/gdfw_datapath.sv]
// ----------------------------------------------------------------------------
// gdfw_datapath
// Adjacency store, distance memory with two read ports, relaxation
// pipeline, loop counters and the diameter accumulator.
// ----------------------------------------------------------------------------
module gdfw_datapath #(
    parameter int MAX_NODES = gdfw_pkg::MAX_NODES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gdfw_pkg::CFG_W-1:0]    cfg_data,
    input  logic [gdfw_pkg::NODE_W-1:0]   node_a,
    input  logic [gdfw_pkg::NODE_W-1:0]   node_b,
    input  gdfw_pkg::cmd_t                cmd,
    output gdfw_pkg::sts_t                sts,
    output logic [gdfw_pkg::DIAM_W-1:0]   diameter,
    output logic                          connected
);
    import gdfw_pkg::*;

    localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DW    = $clog2(MAX_NODES + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int CW    = (DW > CFG_W) ? DW : CFG_W;
    localparam logic [DW-1:0] UNREACH = DW'(MAX_NODES);

    // configuration
    logic [CFG_W-1:0] node_count_reg;
    logic [CW-1:0]    cnt_ext;
    logic [CW-1:0]    max_ext;
    logic [CW-1:0]    n_eff;
    logic [IW-1:0]    n_last;

    // edge load
    logic                 edge_ok;
    logic [IW-1:0]        a_idx;
    logic [IW-1:0]        b_idx;
    logic [IW-1:0]        lo_idx;
    logic [IW-1:0]        hi_idx;
    logic [MAX_NODES-1:0] hi_onehot;

    // adjacency store, upper triangle only: row min(a,b), bit max(a,b)
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] adj_vld_reg;
    logic [MAX_NODES-1:0] adj_rd_reg;
    logic                 adj_ok_reg;

    // loop counters
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;

    // distance memory
    logic [DW-1:0] dist_mem [DEPTH];
    logic [AW-1:0] rd0_addr;
    logic [AW-1:0] rd1_addr;
    logic          rd0_en;
    logic [DW-1:0] rd0_reg;
    logic [DW-1:0] rd1_reg;
    logic [DW-1:0] rik_reg;

    // write-back stage
    logic          p_wr_reg;
    logic          p_cap_reg;
    logic          p_init_reg;
    logic          p_final_reg;
    logic [IW-1:0] p_i_reg;
    logic [IW-1:0] p_j_reg;
    logic [DW:0]   via_sum;
    logic [DW-1:0] via;
    logic [DW-1:0] wr_val;

    // diameter accumulator
    logic          any_reg;
    logic [DW-1:0] best_reg;
    logic [DIAM_W-1:0] diam_reg;
    logic              conn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
        end else if (cfg_we) begin
            node_count_reg <= cfg_data;
        end
    end

    // node count saturated to the store size, zero treated as one node
    always_comb begin
        cnt_ext = CW'(node_count_reg);
        max_ext = CW'(MAX_NODES);
        if (cnt_ext > max_ext) begin
            n_eff = max_ext;
        end else if (cnt_ext == '0) begin
            n_eff = CW'(1);
        end else begin
            n_eff = cnt_ext;
        end
        n_last = IW'(n_eff - CW'(1));
    end

    always_comb begin
        edge_ok = (node_a != node_b) && (CW'(node_a) < n_eff) && (CW'(node_b) < n_eff);
        a_idx   = IW'(node_a);
        b_idx   = IW'(node_b);
        lo_idx  = (a_idx < b_idx) ? a_idx : b_idx;
        hi_idx  = (a_idx < b_idx) ? b_idx : a_idx;
        hi_onehot = {{(MAX_NODES-1){1'b0}}, 1'b1} << hi_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adj_vld_reg <= '0;
        end else if (cmd.clr_adj) begin
            adj_vld_reg <= '0;
        end else if (cmd.load_edge && edge_ok) begin
            adj_vld_reg[lo_idx] <= 1'b1;
        end
    end

    // a row that is not valid yet is rewritten whole
    always_ff @(posedge aclk) begin
        if (cmd.load_edge && edge_ok) begin
            if (adj_vld_reg[lo_idx]) begin
                adj_mem[lo_idx][hi_idx] <= 1'b1;
            end else begin
                adj_mem[lo_idx] <= hi_onehot;
            end
        end
        if (cmd.row_start && (cmd.phase == PH_INIT)) begin
            adj_rd_reg <= adj_mem[i_reg];
            adj_ok_reg <= adj_vld_reg[i_reg];
        end
    end

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (cmd.clr_cnt) begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end else if (cmd.stream) begin
            if (j_reg == n_last) begin
                j_next = '0;
                if (i_reg == n_last) begin
                    i_next = '0;
                    if (cmd.phase == PH_RELAX) begin
                        k_next = k_reg + IW'(1);
                    end
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end else begin
                j_next = j_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    assign sts.col_last = (j_reg == n_last);
    assign sts.row_last = (i_reg == n_last);
    assign sts.k_last   = (k_reg == n_last);

    // port 0: d[i][k] at row start, d[i][j] while streaming
    // port 1: d[j][i] (mirror) during init, d[k][j] during relaxation
    always_comb begin
        rd0_en   = (cmd.phase == PH_RELAX) && (cmd.row_start || cmd.stream);
        rd0_addr = cmd.row_start ? {i_reg, k_reg} : {i_reg, j_reg};
        rd1_addr = (cmd.phase == PH_INIT) ? {j_reg, i_reg} : {k_reg, j_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_wr_reg  <= 1'b0;
            p_cap_reg <= 1'b0;
        end else begin
            p_wr_reg  <= cmd.stream;
            p_cap_reg <= cmd.row_start && (cmd.phase == PH_RELAX);
        end
    end

    always_ff @(posedge aclk) begin
        p_init_reg  <= (cmd.phase == PH_INIT);
        p_final_reg <= (cmd.phase == PH_RELAX) && (k_reg == n_last);
        p_i_reg     <= i_reg;
        p_j_reg     <= j_reg;
        if (p_cap_reg) begin
            rik_reg <= rd0_reg;
        end
    end

    always_comb begin
        via_sum = {1'b0, rik_reg} + {1'b0, rd1_reg};
        via     = (via_sum > {1'b0, UNREACH}) ? UNREACH : via_sum[DW-1:0];
        if (p_init_reg) begin
            if (p_j_reg < p_i_reg) begin
                wr_val = rd1_reg;
            end else if (p_j_reg == p_i_reg) begin
                wr_val = '0;
            end else if (adj_ok_reg && adj_rd_reg[p_j_reg]) begin
                wr_val = DW'(1);
            end else begin
                wr_val = UNREACH;
            end
        end else begin
            wr_val = (via < rd0_reg) ? via : rd0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_wr_reg) begin
            dist_mem[{p_i_reg, p_j_reg}] <= wr_val;
        end
        if (rd0_en) begin
            rd0_reg <= dist_mem[rd0_addr];
        end
        if (cmd.stream) begin
            rd1_reg <= dist_mem[rd1_addr];
        end
    end

    // values written in the last pass are final; track the upper triangle
    always_ff @(posedge aclk) begin
        if (cmd.clr_best) begin
            any_reg  <= 1'b0;
            best_reg <= '0;
        end else if (p_wr_reg && p_final_reg && (p_j_reg > p_i_reg)) begin
            any_reg <= 1'b1;
            if (wr_val > best_reg) begin
                best_reg <= wr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            diam_reg <= any_reg ? DIAM_W'(best_reg) : '1;
            conn_reg <= !any_reg || (best_reg != UNREACH);
        end
    end

    assign diameter  = diam_reg;
    assign connected = conn_reg;

endmodule

[sv/gdfw_ctrl.sv]
// ----------------------------------------------------------------------------
// gdfw_ctrl
// Sequencer for edge loading, matrix init, relaxation passes and result
// hand-off; owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module gdfw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_op,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  gdfw_pkg::sts_t sts,
    output gdfw_pkg::cmd_t cmd
);
    import gdfw_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   s_xfer;
    logic   out_free;

    assign s_xfer   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_op == OP_FINISH)) begin
                    state_next = ST_INIT_ROW;
                end
            end
            ST_INIT_ROW: begin
                state_next = ST_INIT_STREAM;
            end
            ST_INIT_STREAM: begin
                if (sts.col_last) begin
                    state_next = sts.row_last ? ST_RELAX_ROW : ST_INIT_ROW;
                end
            end
            ST_RELAX_ROW: begin
                state_next = ST_RELAX_STREAM;
            end
            ST_RELAX_STREAM: begin
                if (sts.col_last) begin
                    state_next = (sts.row_last && sts.k_last) ? ST_DRAIN : ST_RELAX_ROW;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.phase = PH_INIT;
        s_tready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_xfer) begin
                    if (s_op == OP_EDGE) begin
                        cmd.load_edge = 1'b1;
                    end else begin
                        cmd.clr_cnt  = 1'b1;
                        cmd.clr_best = 1'b1;
                    end
                end
            end
            ST_INIT_ROW: begin
                cmd.row_start = 1'b1;
            end
            ST_INIT_STREAM: begin
                cmd.stream = 1'b1;
            end
            ST_RELAX_ROW: begin
                cmd.row_start = 1'b1;
                cmd.phase     = PH_RELAX;
            end
            ST_RELAX_STREAM: begin
                cmd.stream = 1'b1;
                cmd.phase  = PH_RELAX;
            end
            ST_DRAIN: begin
                cmd.phase = PH_RELAX;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    cmd.clr_adj     = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_result) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[sv/gdfw_checker.sv]
// ----------------------------------------------------------------------------
// gdfw_checker
// Port-level checks for the graph diameter block, bound to the top level.
// ----------------------------------------------------------------------------
module gdfw_checker #(
    parameter int MAX_NODES = gdfw_pkg::MAX_NODES_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gdfw_pkg::M_TDATA_W-1:0] m_tdata
);
    import gdfw_pkg::*;

    localparam logic [DIAM_W-1:0] UNREACH_CODE = DIAM_W'(MAX_NODES);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an edge transfer never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_EDGE) && !m_tvalid |=> !m_tvalid)
        else $error("edge load produced a result");

    // a finish transfer blocks the input while the sweep runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_FINISH) |=> !s_tready)
        else $error("input accepted during sweep");

    // disconnected graphs report the unreachable code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[DIAM_W] |-> m_tdata[DIAM_W-1:0] == UNREACH_CODE)
        else $error("disconnected result without unreachable code");

endmodule

bind graph_diameter_floyd_warshall gdfw_checker #(
    .MAX_NODES (MAX_NODES)
) u_gdfw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/graph_diameter_floyd_warshall_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_diameter_floyd_warshall_check
// Passive checker for the graph diameter block. It follows node_count writes
// and edge loads into an adjacency store of its own. On each finish it works
// out all-pairs hop counts and queues the expected diameter and connected
// flag. Each result transfer is then compared against the oldest entry.
// ----------------------------------------------------------------------------
module graph_diameter_floyd_warshall_check #(
    parameter int MAX_NODES = gdfw_pkg::MAX_NODES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [gdfw_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [gdfw_pkg::S_TDATA_W-1:0]    s_tdata,  // node_a[5:0], node_b[11:6]
    input  logic                              s_tuser,  // op
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [gdfw_pkg::M_TDATA_W-1:0]    m_tdata,  // diameter[7:0], connected[8]
    output int                                mismatches,
    output int                                outstanding
);

    typedef struct packed {
        logic signed [gdfw_pkg::DIAM_W-1:0] diameter;
        logic                               connected;
    } diam_result_t;

    logic [gdfw_pkg::CFG_W-1:0] node_count;
    logic [MAX_NODES-1:0]       adj_rows [MAX_NODES];
    int                         hops [MAX_NODES][MAX_NODES];
    diam_result_t               diam_q [$];

    function automatic int nodes_in_use();
        if (node_count > MAX_NODES) return MAX_NODES;
        if (node_count == 0) return 1;
        return int'(node_count);
    endfunction

    // unit-cost all-pairs relaxation, MAX_NODES doubles as the unreachable mark
    function automatic diam_result_t solve_diameter();
        int n;
        int via;
        int best;
        diam_result_t res;
        n = nodes_in_use();
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                hops[i][j] = (i == j) ? 0 : (adj_rows[i][j] ? 1 : MAX_NODES);
            end
        end
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    via = hops[i][k] + hops[k][j];
                    if (via > MAX_NODES) via = MAX_NODES;
                    if (via < hops[i][j]) hops[i][j] = via;
                end
            end
        end
        best = -1;
        res.connected = 1'b1;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                if (hops[i][j] > best) best = hops[i][j];
            end
        end
        if (best >= MAX_NODES) begin
            best = MAX_NODES;
            res.connected = 1'b0;
        end
        res.diameter = best[gdfw_pkg::DIAM_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        diam_result_t want;
        logic [gdfw_pkg::NODE_W-1:0] na;
        logic [gdfw_pkg::NODE_W-1:0] nb;
        if (!aresetn) begin
            node_count = gdfw_pkg::NODE_COUNT_RST;
            foreach (adj_rows[r]) adj_rows[r] = '0;
            diam_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (diam_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = diam_q.pop_front();
                    if (m_tdata[7:0] !== want.diameter)
                        report_mismatch("diameter", $signed(m_tdata[7:0]), want.diameter);
                    if (m_tdata[8] !== want.connected)
                        report_mismatch("connected", int'(m_tdata[8]), int'(want.connected));
                    if (m_tdata[gdfw_pkg::M_TDATA_W-1:9] !== '0)
                        report_mismatch("tdata padding",
                                        int'(m_tdata[gdfw_pkg::M_TDATA_W-1:9]), 0);
                end
            end
            if (cfg_valid && cfg_ready) node_count = cfg_data;
            if (s_tvalid && s_tready) begin
                na = s_tdata[5:0];
                nb = s_tdata[11:6];
                if (s_tuser == gdfw_pkg::OP_FINISH) begin
                    diam_q.push_back(solve_diameter());
                    foreach (adj_rows[r]) adj_rows[r] = '0;
                end else if (na != nb && na < nodes_in_use() && nb < nodes_in_use()) begin
                    adj_rows[na][nb] = 1'b1;
                    adj_rows[nb][na] = 1'b1;
                end
            end
            outstanding = diam_q.size();
        end
    end

endmodule

[test/graph_diameter_floyd_warshall_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_diameter_floyd_warshall_test
// Drives edge loads, finishes and node_count writes into the diameter block:
// a directed part covering the node count extremes and ignored edges, then
// random trees, sparse graphs and noise at small node counts. Both channels
// idle at random; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module graph_diameter_floyd_warshall_test;

    localparam int MAX_NODES     = gdfw_pkg::MAX_NODES_DEF;
    localparam int HOLD_CYCLES   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int EDGE_TARGET   = 930;
    localparam int FINISH_TARGET = 60;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [gdfw_pkg::CFG_W-1:0]     cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [gdfw_pkg::S_TDATA_W-1:0] s_tdata;  // node_a[5:0], node_b[11:6]
    logic                           s_tuser;  // op
    logic                           m_tvalid;
    logic                           m_tready;
    logic [gdfw_pkg::M_TDATA_W-1:0] m_tdata;  // diameter[7:0], connected[8]

    int mismatches;
    int outstanding;
    int edges_sent;
    int finishes_sent;
    bit calm;
    bit hold_off_req;

    graph_diameter_floyd_warshall #(
        .MAX_NODES (MAX_NODES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    graph_diameter_floyd_warshall_check #(
        .MAX_NODES (MAX_NODES)
    ) i_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // two full 64-node sweeps dominate, the rest stays well below that
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            m_tready = calm || ($urandom_range(99) >= 35);
        end
    end

    function automatic int active_nodes(int count);
        if (count > MAX_NODES) return MAX_NODES;
        if (count == 0) return 1;
        return count;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(logic op, logic [5:0] na, logic [5:0] nb);
        while (!calm && $urandom_range(99) < 35) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0000, nb, na};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_edge(logic [5:0] na, logic [5:0] nb);
        send_item(gdfw_pkg::OP_EDGE, na, nb);
        edges_sent++;
    endtask

    task automatic send_finish();
        send_item(gdfw_pkg::OP_FINISH, 6'($urandom_range(63)), 6'($urandom_range(63)));
        finishes_sent++;
    endtask

    task automatic write_node_count(logic [gdfw_pkg::CFG_W-1:0] count);
        cfg_valid = 1'b1;
        cfg_data  = count;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // wait out every pending result plus the tail of the last edge write
    task automatic settle_idle();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic send_graph(int n);
        int shape;
        int count;
        int parent;
        shape = $urandom_range(99);
        count = 0;
        if (n >= 2 && shape < 45) begin
            // random spanning tree keeps it connected, chords shorten paths
            for (int v = 1; v < n; v++) begin
                parent = $urandom_range(v - 1);
                if ($urandom_range(1)) send_edge(6'(v), 6'(parent));
                else send_edge(6'(parent), 6'(v));
            end
            count = $urandom_range(3);
        end else if (n >= 2 && shape < 85) begin
            count = $urandom_range(2 * n);
        end
        repeat (count) send_edge(6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)));
        // noise: self-loops, repeats and endpoints beyond node_count
        if (shape >= 80) begin
            repeat ($urandom_range(1, 6))
                send_edge(6'($urandom_range(63)), 6'($urandom_range(63)));
        end
        send_finish();
    endtask

    task automatic run_random_round(int graphs);
        int pick;
        int count;
        pick = $urandom_range(99);
        if (pick < 4) count = 0;
        else if (pick < 12) count = 1;
        else if (pick < 80) count = $urandom_range(2, 8);
        else count = $urandom_range(9, 12);
        settle_idle();
        write_node_count(7'(count));
        repeat (graphs) send_graph(active_nodes(count));
    endtask

    initial begin
        int round;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = gdfw_pkg::OP_EDGE;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        edges_sent    = 0;
        finishes_sent = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset node_count: extreme endpoints, repeat, self-loop; stays disconnected
        send_edge(0, 63);
        send_edge(63, 0);
        send_edge(5, 5);
        send_edge(1, 2);
        send_finish();

        // count above the node limit saturates; a path over all nodes is the longest
        settle_idle();
        write_node_count(127);
        for (int v = 1; v < MAX_NODES; v++) send_edge(6'(v - 1), 6'(v));
        send_finish();

        // zero and one node: edges dropped, diameter reads -1
        settle_idle();
        write_node_count(0);
        send_edge(0, 1);
        send_finish();
        settle_idle();
        write_node_count(1);
        send_edge(1, 0);
        send_finish();

        // two nodes, empty then joined
        settle_idle();
        write_node_count(2);
        send_finish();
        send_edge(1, 0);
        send_finish();

        // endpoint equal to node_count is dropped at load time
        settle_idle();
        write_node_count(3);
        send_edge(3, 1);
        send_edge(0, 3);
        send_edge(0, 1);
        send_edge(2, 1);
        send_finish();

        // an edge loaded under a larger count lies outside a smaller finish
        settle_idle();
        write_node_count(8);
        send_edge(0, 7);
        send_edge(0, 1);
        settle_idle();
        write_node_count(2);
        send_finish();

        round = 0;
        while (edges_sent < EDGE_TARGET || finishes_sent < FINISH_TARGET) begin
            calm = (round >= 10 && round < 16);
            if (round == 20) begin
                // results back up behind the hold-off until a finish stalls the input
                settle_idle();
                hold_off_req = 1'b1;
                run_random_round(4);
            end else begin
                run_random_round($urandom_range(1, 4));
            end
            round++;
        end
        calm = 1'b0;

        settle_idle();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
